### hw/rtl/ntmh_pkg.sv
`default_nettype none
package ntmh_pkg;

  localparam int TableDepthDef  = 1024;
  localparam int CordicStepsDef = 16;
  localparam int MaxSteps       = 24;
  localparam int StampW         = 40;
  localparam int RawW           = 16;
  localparam int CalW           = 26;
  localparam int HeadW          = 15;
  localparam int CfgW           = 24;
  localparam int CfgIdxW        = 3;
  localparam int AngW           = 26;

  typedef enum logic [2:0] {
    REG_OFFSET_X = 3'd0,
    REG_OFFSET_Y = 3'd1,
    REG_OFFSET_Z = 3'd2,
    REG_COEF_XX  = 3'd3,
    REG_COEF_XY  = 3'd4,
    REG_COEF_YY  = 3'd5,
    REG_COEF_ZZ  = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_DIFF,
    ST_MUL1,
    ST_MUL2,
    ST_SUM,
    ST_CORDIC,
    ST_HEAD,
    ST_OUT
  } state_t;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // arctangent of 2^-i in 1/65536 degree
  function automatic logic [AngW-1:0] atan_q16(input logic [4:0] i);
    logic [AngW-1:0] r;
    begin
      case (i)
        5'd0:  r = 26'd2949120;
        5'd1:  r = 26'd1740967;
        5'd2:  r = 26'd919879;
        5'd3:  r = 26'd466945;
        5'd4:  r = 26'd234379;
        5'd5:  r = 26'd117304;
        5'd6:  r = 26'd58666;
        5'd7:  r = 26'd29335;
        5'd8:  r = 26'd14668;
        5'd9:  r = 26'd7334;
        5'd10: r = 26'd3667;
        5'd11: r = 26'd1833;
        5'd12: r = 26'd917;
        5'd13: r = 26'd458;
        5'd14: r = 26'd229;
        5'd15: r = 26'd115;
        5'd16: r = 26'd57;
        5'd17: r = 26'd29;
        5'd18: r = 26'd14;
        5'd19: r = 26'd7;
        5'd20: r = 26'd4;
        5'd21: r = 26'd2;
        5'd22: r = 26'd1;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

### hw/rtl/ntmh_cordic.sv
`default_nettype none
module ntmh_cordic
  import ntmh_pkg::*;
#(
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic signed [CalW-1:0] in_x,
  input  wire logic signed [CalW-1:0] in_y,
  output logic                        done,
  output logic [HeadW-1:0]            heading
);

  localparam int Steps = (CORDIC_STEPS > MaxSteps) ? MaxSteps : CORDIC_STEPS;
  // x grows by under 1.65 and keeps the negated minimum; 29 bits suffice
  localparam int XW = CalW + 3;

  logic signed [XW-1:0] x, y;
  logic signed [AngW+1:0] ang;
  logic [4:0] step;
  logic busy;
  logic zero;

  logic signed [XW-1:0] xs, ys;
  logic signed [AngW+1:0] ang_w, ang_r;
  logic [AngW+1:0] full;

  assign xs = x >>> step;
  assign ys = y >>> step;
  assign full = (AngW+2)'(360 * 65536);

  // iterate one micro-rotation a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        done <= 1'b0;
        busy <= 1'b1;
        step <= '0;
        zero <= (in_x == 0) && (in_y == 0);
        if (in_x < 0) begin
          x   <= -XW'(in_x);
          y   <= -XW'(in_y);
          ang <= (AngW+2)'(180 * 65536);
        end else begin
          x   <= XW'(in_x);
          y   <= XW'(in_y);
          ang <= '0;
        end
      end else if (busy) begin
        if (step == 5'(Steps)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          done <= 1'b0;
          step <= step + 5'd1;
          if (y >= 0) begin
            x   <= x + ys;
            y   <= y - xs;
            ang <= ang + $signed({2'b00, atan_q16(step)});
          end else begin
            x   <= x - ys;
            y   <= y + xs;
            ang <= ang - $signed({2'b00, atan_q16(step)});
          end
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  // wrap into one turn and round to 1/64 degree
  logic [AngW+1:0] h_full;
  always_comb begin
    ang_w = ang;
    if (ang_w < 0) ang_w = ang_w + $signed(full);
    else if (ang_w >= $signed(full)) ang_w = ang_w - $signed(full);
    ang_r  = ang_w + 28'sd512;
    h_full = 28'(ang_r >>> 10);
  end

  assign heading = (zero || h_full >= 28'd23040) ? '0 : h_full[HeadW-1:0];

endmodule
`default_nettype wire

### hw/rtl/nearest_time_magnetometer_heading.sv
// Channel | Dir | Payload (low bit up)
// s_axis  | in  | tdata: stamp_ms[39:0], raw_x, raw_y, raw_z; tuser: command
// m_axis  | out | tdata: match_stamp, cal_x, cal_y, cal_z, heading; tuser: found, overflow
// cfg     | in  | cfg_we, cfg_idx (register index), cfg_data
// An append is written at its accepting edge; the next item is taken the cycle after.
// A query with records scans every record, then steps through ST_FETCH, ST_DIFF,
// ST_MUL1, ST_MUL2 and ST_SUM, runs the CORDIC of CORDIC_STEPS (capped at 24)
// micro-rotations, and in ST_HEAD loads the result and raises m_axis_tvalid. Dropped appends and empty queries
// give their result the cycle after. Input waits while a result is held; after a
// query result is taken, the sequencer goes from ST_OUT to ST_IDLE before input resumes.
// Reset empties the table at once (entry count cleared); no clearing pass.
`default_nettype none
module nearest_time_magnetometer_heading
  import ntmh_pkg::*;
#(
  parameter int TABLE_DEPTH  = TableDepthDef,
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [87:0]   s_axis_tdata,  // stamp_ms, raw_x, raw_y, raw_z
  input  wire logic          s_axis_tuser,  // command
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [135:0]       m_axis_tdata,  // match_stamp, cal_x, cal_y, cal_z, heading, pad
  output logic [1:0]         m_axis_tuser,  // found, overflow
  input  wire logic          cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_idx,
  input  wire logic [CfgW-1:0]    cfg_data
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int MW = StampW + 3 * RawW;

  // configuration registers
  logic signed [23:0] off_x, off_y, off_z;
  logic signed [15:0] c_xx, c_xy, c_yy, c_zz;
  always_ff @(posedge clk) begin
    if (rst) begin
      off_x <= -24'sd252060;
      off_y <= 24'sd95739;
      off_z <= 24'sd80164;
      c_xx  <= 16'sd15652;
      c_xy  <= -16'sd392;
      c_yy  <= 16'sd17175;
      c_zz  <= 16'sd16369;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_OFFSET_X: off_x <= cfg_data;
        REG_OFFSET_Y: off_y <= cfg_data;
        REG_OFFSET_Z: off_z <= cfg_data;
        REG_COEF_XX:  c_xx  <= cfg_data[15:0];
        REG_COEF_XY:  c_xy  <= cfg_data[15:0];
        REG_COEF_YY:  c_yy  <= cfg_data[15:0];
        REG_COEF_ZZ:  c_zz  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // record memory: time and three raw axes
  logic [MW-1:0] mem [TABLE_DEPTH];
  logic [MW-1:0] rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= s_axis_tdata[MW-1:0];
    rd_data <= mem[rd_addr];
  end

  state_t state, state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] scan_idx;     // next address to read
  logic          rd_valid;
  logic [StampW-1:0] q_stamp;
  logic [StampW-1:0] best_d, best_t;
  logic [MW-1:0] best_rec;
  logic          have_best;
  logic signed [24:0] dx, dy, dz;
  logic signed [40:0] p_a, p_b;
  logic signed [40:0] p_c, p_d, p_z;
  logic signed [CalW-1:0] cx, cy, cz;
  logic cord_start, cord_done;
  logic [HeadW-1:0] cord_head;

  logic accept_in;
  assign accept_in = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE) && !m_axis_tvalid;

  assign wr_en   = accept_in && (s_axis_tuser == CMD_APPEND) && (count < CW'(TABLE_DEPTH));
  assign wr_addr = count[AW-1:0];
  assign rd_addr = scan_idx[AW-1:0];

  // distance of the record being read
  logic [StampW-1:0] rd_t, rd_d;
  assign rd_t = rd_data[StampW-1:0];
  assign rd_d = (rd_t >= q_stamp) ? rd_t - q_stamp : q_stamp - rd_t;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:
        if (accept_in && s_axis_tuser == CMD_QUERY && count != '0) state_next = ST_SCAN;
      ST_SCAN:   if (scan_idx == count) state_next = ST_FETCH;
      ST_FETCH:  state_next = ST_DIFF;
      ST_DIFF:   state_next = ST_MUL1;
      ST_MUL1:   state_next = ST_MUL2;
      ST_MUL2:   state_next = ST_SUM;
      ST_SUM:    state_next = ST_CORDIC;
      ST_CORDIC: if (cord_done) state_next = ST_HEAD;
      ST_HEAD:   state_next = ST_OUT;
      ST_OUT:    if (!m_axis_tvalid) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // outputs of the sequencer
  always_comb begin
    cord_start = 1'b0;
    unique case (state)
      ST_SUM:  cord_start = 1'b1;
      default: cord_start = 1'b0;
    endcase
  end

  function automatic logic signed [CalW-1:0] rsat(input logic signed [41:0] acc);
    logic signed [41:0] r;
    begin
      r = (acc + 42'sd8192) >>> 14;
      if (r > 42'sd33554431) return 26'sh1FFFFFF;
      if (r < -42'sd33554432) return 26'sh2000000;
      return r[CalW-1:0];
    end
  endfunction

  // scan and arithmetic datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      scan_idx <= '0;
      rd_valid <= 1'b0;
      have_best <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (wr_en) count <= count + CW'(1);
      rd_valid <= (state == ST_SCAN) && (scan_idx != count);
      if (accept_in) begin
        q_stamp   <= s_axis_tdata[StampW-1:0];
        scan_idx  <= '0;
        have_best <= 1'b0;
        if (s_axis_tuser == CMD_APPEND && !wr_en) begin
          m_axis_tvalid <= 1'b1;
          m_axis_tuser  <= 2'b10;
          m_axis_tdata  <= '0;
        end else if (s_axis_tuser == CMD_QUERY && count == '0) begin
          m_axis_tvalid <= 1'b1;
          m_axis_tuser  <= 2'b00;
          m_axis_tdata  <= '0;
        end
      end
      if (state == ST_SCAN && scan_idx != count) begin
        scan_idx <= scan_idx + CW'(1);
      end
      // keep the first-stored nearest record; a tie keeps the lower address
      if (rd_valid && (!have_best || rd_d < best_d)) begin
        have_best <= 1'b1;
        best_d    <= rd_d;
        best_t    <= rd_t;
        best_rec  <= rd_data;
      end
      if (state == ST_DIFF) begin
        dx <= $signed({best_rec[StampW+RawW-1], best_rec[StampW +: RawW], 8'd0})
              - $signed({off_x[23], off_x});
        dy <= $signed({best_rec[StampW+2*RawW-1], best_rec[StampW+RawW +: RawW], 8'd0})
              - $signed({off_y[23], off_y});
        dz <= $signed({best_rec[StampW+3*RawW-1], best_rec[StampW+2*RawW +: RawW], 8'd0})
              - $signed({off_z[23], off_z});
      end
      // form all five products at once
      if (state == ST_MUL1) begin
        p_a <= 41'(c_xx * dx);
        p_b <= 41'(c_xy * dy);
        p_c <= 41'(c_xy * dx);
        p_d <= 41'(c_yy * dy);
        p_z <= 41'(c_zz * dz);
      end
      // round and saturate all axes before the CORDIC starts
      if (state == ST_MUL2) begin
        cx  <= rsat(42'(p_a) + 42'(p_b));
        cy  <= rsat(42'(p_c) + 42'(p_d));
        cz  <= rsat(42'(p_z));
      end
      if (state == ST_HEAD) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tuser  <= 2'b01;
        m_axis_tdata  <= {3'b000, cord_head, cz, cy, cx, best_t};
      end
    end
  end

  ntmh_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(cord_start),
    .in_x(cx), .in_y(cy), .done(cord_done), .heading(cord_head)
  );

  // the fill count never passes the depth
  assert property (@(posedge clk) disable iff (rst) count <= CW'(TABLE_DEPTH))
    else $error("fill count beyond depth");
  // a found result carries no overflow
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("found with overflow");
  // the scan never runs past the fill count
  assert property (@(posedge clk) disable iff (rst) scan_idx <= count)
    else $error("scan past fill");

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
`default_nettype none
module tb_top
  import ntmh_pkg::*;
;

  localparam int Depth    = 1024;
  localparam int Steps    = 16;
  localparam int NumItems = 540;
  localparam longint CycleLimit = 4000000;

  typedef struct packed {
    logic              cmd;
    logic [39:0]       stamp;
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic signed [15:0] rz;
  } sample_item_t;

  typedef struct packed {
    logic              found;
    logic              overflow;
    logic [39:0]       stamp;
    logic [25:0]       cx;
    logic [25:0]       cy;
    logic [25:0]       cz;
    logic [14:0]       heading;
  } heading_res_t;

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [87:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [135:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0] cfg_data;

  nearest_time_magnetometer_heading dut (.*);

  // predictor state
  logic signed [23:0] off_x, off_y, off_z;
  logic signed [15:0] k_xx, k_xy, k_yy, k_zz;
  int unsigned        rec_count;
  logic [39:0]        rec_stamp [Depth];
  logic signed [15:0] rec_raw   [Depth][3];

  sample_item_t pending_items[$];
  heading_res_t expected_results[$];
  int     err_count;
  longint cycle_count;
  int     results_seen, overflows_seen;
  bit     src_quiet, sink_quiet;

  // queue an item for the driver
  function automatic void add_item(sample_item_t it);
    pending_items = {pending_items, it};
  endfunction

  // queue an expected result for the monitor
  function automatic void add_expect(heading_res_t r);
    expected_results = {expected_results, r};
  endfunction

  // angle of every atan(2^-i) in 1/65536 degree
  function automatic longint atan_step(int i);
    longint tab [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                         29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                         57, 29, 14, 7, 4, 2, 1, 0};
    return tab[i];
  endfunction

  function automatic longint rnd_sat(longint acc);
    longint r;
    r = (acc + 8192) >>> 14;
    if (r > 33554431) r = 33554431;
    if (r < -33554432) r = -33554432;
    return r;
  endfunction

  function automatic logic [14:0] compass_heading(longint x, longint y);
    longint ang, base, xs, ys, h;
    ang = 0;
    base = 0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      base = 180 * 65536;
    end
    for (int i = 0; i < Steps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; ang += atan_step(i);
      end else begin
        x = x - ys; y = y + xs; ang -= atan_step(i);
      end
    end
    ang += base;
    while (ang < 0) ang += 360 * 65536;
    while (ang >= 360 * 65536) ang -= 360 * 65536;
    h = (ang + 512) >>> 10;
    if (h >= 23040) h = 0;
    return h[14:0];
  endfunction

  // apply one item to the predictor; queue the result it causes
  task automatic predict_heading(input sample_item_t it);
    heading_res_t r;
    longint best_d, d, dx, dy, dz, cx, cy, cz;
    int best;
    r = '0;
    best = 0;
    best_d = 0;
    if (it.cmd == CMD_APPEND) begin
      if (rec_count >= Depth) begin
        r.overflow = 1'b1;
        add_expect(r);
      end else begin
        rec_stamp[rec_count] = it.stamp;
        rec_raw[rec_count][0] = it.rx;
        rec_raw[rec_count][1] = it.ry;
        rec_raw[rec_count][2] = it.rz;
        rec_count++;
      end
      return;
    end
    if (rec_count == 0) begin
      add_expect(r);
      return;
    end
    for (int i = 0; i < rec_count; i++) begin
      d = (rec_stamp[i] >= it.stamp) ? longint'(rec_stamp[i] - it.stamp)
                                     : longint'(it.stamp - rec_stamp[i]);
      if (i == 0 || d < best_d) begin
        best_d = d;
        best = i;
      end
    end
    dx = longint'(rec_raw[best][0]) * 256 - longint'(off_x);
    dy = longint'(rec_raw[best][1]) * 256 - longint'(off_y);
    dz = longint'(rec_raw[best][2]) * 256 - longint'(off_z);
    cx = rnd_sat(longint'(k_xx) * dx + longint'(k_xy) * dy);
    cy = rnd_sat(longint'(k_xy) * dx + longint'(k_yy) * dy);
    cz = rnd_sat(longint'(k_zz) * dz);
    r.found = 1'b1;
    r.stamp = rec_stamp[best];
    r.cx = cx[25:0];
    r.cy = cy[25:0];
    r.cz = cz[25:0];
    r.heading = compass_heading(cx, cy);
    add_expect(r);
  endtask

  // clock and cycle limit
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // driver: present the oldest pending item, with random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        predict_heading(pending_items.pop_front());
      end
      if (pending_items.size() > 0 && (src_quiet || $urandom_range(99) >= 30)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pending_items[0].rz, pending_items[0].ry,
                          pending_items[0].rx, pending_items[0].stamp};
        s_axis_tuser  <= pending_items[0].cmd;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // sink stall pattern
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= sink_quiet || ($urandom_range(99) >= 30);
  end

  // monitor: compare each result against the oldest expectation
  always @(posedge clk) begin
    heading_res_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.found    = m_axis_tuser[0];
      got.overflow = m_axis_tuser[1];
      got.stamp    = m_axis_tdata[39:0];
      got.cx       = m_axis_tdata[65:40];
      got.cy       = m_axis_tdata[91:66];
      got.cz       = m_axis_tdata[117:92];
      got.heading  = m_axis_tdata[132:118];
      results_seen++;
      if (got.overflow) overflows_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected result %p", got);
        err_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, got.found); err_count++;
        end
        if (got.overflow !== want.overflow) begin
          $error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
          err_count++;
        end
        if (got.stamp !== want.stamp) begin
          $error("match_stamp: expected %0d, got %0d", want.stamp, got.stamp);
          err_count++;
        end
        if (got.cx !== want.cx) begin
          $error("cal_x: expected %0d, got %0d", $signed(want.cx), $signed(got.cx));
          err_count++;
        end
        if (got.cy !== want.cy) begin
          $error("cal_y: expected %0d, got %0d", $signed(want.cy), $signed(got.cy));
          err_count++;
        end
        if (got.cz !== want.cz) begin
          $error("cal_z: expected %0d, got %0d", $signed(want.cz), $signed(got.cz));
          err_count++;
        end
        if (got.heading !== want.heading) begin
          $error("heading: expected %0d, got %0d", want.heading, got.heading);
          err_count++;
        end
      end
    end
  end

  function automatic sample_item_t make_append(logic [39:0] st, logic [15:0] x,
                                               logic [15:0] y, logic [15:0] z);
    sample_item_t it;
    it.cmd = CMD_APPEND; it.stamp = st; it.rx = x; it.ry = y; it.rz = z;
    return it;
  endfunction

  function automatic sample_item_t make_query(logic [39:0] st);
    sample_item_t it;
    it = '0;
    it.cmd = CMD_QUERY;
    it.stamp = st;
    it.rx = 16'($urandom);
    it.ry = 16'($urandom);
    it.rz = 16'($urandom);
    return it;
  endfunction

  function automatic logic [39:0] rand_stamp();
    return {8'($urandom), 32'($urandom)};
  endfunction

  // hold until the block is idle and nothing is in flight
  task automatic drain();
    while (pending_items.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (Depth + 80) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [23:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_OFFSET_X: off_x = val;
      REG_OFFSET_Y: off_y = val;
      REG_OFFSET_Z: off_z = val;
      REG_COEF_XX:  k_xx = val[15:0];
      REG_COEF_XY:  k_xy = val[15:0];
      REG_COEF_YY:  k_yy = val[15:0];
      default:      k_zz = val[15:0];
    endcase
  endtask

  task automatic write_all(input logic [23:0] ox, oy, oz,
                           input logic [15:0] xx, xy, yy, zz);
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy);
    write_reg(REG_OFFSET_Z, oz);
    write_reg(REG_COEF_XX, {8'h0, xx});
    write_reg(REG_COEF_XY, {8'h0, xy});
    write_reg(REG_COEF_YY, {8'h0, yy});
    write_reg(REG_COEF_ZZ, {8'h0, zz});
  endtask

  // random burst: mostly appends near a moving time base, mixed with queries near it or at a random time
  task automatic random_burst(input int n);
    logic [39:0] t;
    int sel;
    t = rand_stamp();
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 55) begin
        t = t + 40'($urandom_range(40));
        add_item(make_append(t, 16'($urandom), 16'($urandom), 16'($urandom)));
      end else if (sel < 90) begin
        add_item(make_query(t - 40'($urandom_range(200))));
      end else begin
        add_item(make_query(rand_stamp()));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    cycle_count = 0;
    err_count = 0;
    src_quiet = 1'b0;
    sink_quiet = 1'b0;
    off_x = -24'sd252060; off_y = 24'sd95739; off_z = 24'sd80164;
    k_xx = 16'sd15652; k_xy = -16'sd392; k_yy = 16'sd17175; k_zz = 16'sd16369;
    rec_count = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty query, extremes, equal-distance tie, zero vector
    add_item(make_query(40'h0));
    add_item(make_append(40'd100, 16'h7fff, 16'h8000, 16'h7fff));
    add_item(make_append(40'd120, 16'h8000, 16'h7fff, 16'h8000));
    add_item(make_query(40'd110));
    add_item(make_query(40'hff_ffff_ffff));
    add_item(make_append(40'hff_ffff_ffff, 16'hffff, 16'h0001, 16'h0));
    add_item(make_query(40'h0));
    add_item(make_query(40'hff_ffff_fff0));
    add_item(make_append(40'd120, 16'h0, 16'h0, 16'h0));
    add_item(make_query(40'd121));
    drain();
    write_all(24'h0, 24'h0, 24'h0, 16'h4000, 16'h0, 16'h4000, 16'h4000);
    add_item(make_query(40'd120));
    add_item(make_query(40'd119));
    drain();
    // extreme matrix and offsets, driving saturation
    write_all(24'h7fffff, 24'h800000, 24'h7fffff, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    add_item(make_query(40'd100));
    add_item(make_query(40'd120));
    add_item(make_query(40'hff_ffff_ffff));

    // random under the extreme settings, with no idling on either side
    src_quiet = 1'b1; sink_quiet = 1'b1;
    random_burst(60);
    drain();
    src_quiet = 1'b0; sink_quiet = 1'b0;
    write_all(24'($urandom), 24'($urandom), 24'($urandom),
              16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    random_burst(200);
    drain();
    write_all(24'h800000, 24'h7fffff, 24'h800000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    random_burst(120);
    drain();
    // moderate settings for the last burst
    write_all(24'($urandom_range(2000)), 24'($urandom_range(2000)), 24'h0,
              16'h3f00, 16'h0100, 16'h4100, 16'h4000);
    random_burst(140);
    drain();

    $display("tb_top: %0d results checked (%0d overflow), table reached %0d records",
             results_seen, overflows_seen, rec_count);
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
